// ===== src/leb_pkg.sv =====
`timescale 1ns / 1ps

package leb_pkg;

  // Edit command codes carried in the mode field.
  localparam logic [2:0] MODE_INSERT    = 3'd0;
  localparam logic [2:0] MODE_BACKSPACE = 3'd1;
  localparam logic [2:0] MODE_LEFT      = 3'd2;
  localparam logic [2:0] MODE_RIGHT     = 3'd3;
  localparam logic [2:0] MODE_CLEAR     = 3'd4;
  localparam logic [2:0] MODE_READ      = 3'd5;
  localparam logic [2:0] MODE_ACK       = 3'd6;

  // Fixed field widths.
  localparam int CHAR_W = 8;
  localparam int POS_W  = 8;
  localparam int CAP_W  = 9;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_INS_CHK,
    ST_INS_WR,
    ST_BS_CHK,
    ST_BS_WR,
    ST_RD_WAIT,
    ST_DONE
  } state_t;

  // Source of the text store read address.
  typedef enum logic [1:0] {
    RA_INS_SRC,
    RA_BS_SRC,
    RA_READ_IDX
  } raddr_sel_t;

  typedef struct packed {
    logic       capture;
    logic       cfg_write;
    logic       mark_edit;
    logic       ack;
    logic       clear;
    logic       mv_left;
    logic       mv_right;
    logic       ins_start;
    logic       ins_step;
    logic       ins_finish;
    logic       bs_start;
    logic       bs_step;
    logic       bs_finish;
    logic       rd_clear;
    logic       rd_load;
    raddr_sel_t raddr_sel;
    logic       load_out;
  } cmd_t;

  typedef struct packed {
    logic [2:0] mode;
    logic       char_zero;
    logic       at_limit;
    logic       cursor_zero;
    logic       ptr_gt_cursor;
    logic       ptr_lt_length;
    logic       idx_in_range;
  } status_t;

endpackage

// ===== src/line_edit_buffer.sv =====
`timescale 1ns / 1ps

// Single-line text buffer with an edit cursor. Each transfer on the input
// channel carries one edit command (insert, backspace, left, right, clear,
// read, acknowledge) and produces exactly one result transfer reporting the
// cursor position, text length, changed flag and, for reads, the byte read.
// Commands are handled one at a time by a sequencer over a single-port-pair
// text memory of DEPTH bytes. Insert and backspace move the tail of the text
// one byte at a time through the memory's registered read port; an insert
// into a full buffer drops its last byte. A new command is taken once the
// previous result has been placed in the output register, even while
// that result still waits to be taken. Writing the capacity register (only
// while no command is in flight) empties the buffer; capacity acts as if
// clamped into 2 to DEPTH, and the text holds at most capacity minus one
// characters. The stored bytes need no clearing after reset.
module line_edit_buffer #(
  parameter int DEPTH = 256
) (
  input  logic                       clk,
  input  logic                       rst,

  // Command channel.
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [2:0]                 mode,
  input  logic [leb_pkg::CHAR_W-1:0] char_code,
  input  logic [leb_pkg::POS_W-1:0]  read_index,

  // Capacity register write channel.
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [leb_pkg::CAP_W-1:0]  capacity,

  // Result channel.
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [leb_pkg::POS_W-1:0]  cursor_pos,
  output logic [leb_pkg::POS_W-1:0]  text_length,
  output logic                       changed,
  output logic [leb_pkg::CHAR_W-1:0] read_char
);

  // The controller sequences each command; the datapath holds the cursor,
  // length, changed flag, text memory and the result register.
  leb_pkg::cmd_t    cmd;
  leb_pkg::status_t status;

  leb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status   (status),
    .cmd      (cmd)
  );

  leb_datapath #(
    .DEPTH(DEPTH)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .mode       (mode),
    .char_code  (char_code),
    .read_index (read_index),
    .capacity   (capacity),
    .cursor_pos (cursor_pos),
    .text_length(text_length),
    .changed    (changed),
    .read_char  (read_char)
  );

endmodule

// ===== src/leb_ram.sv =====
`timescale 1ns / 1ps

module leb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/leb_ctrl.sv =====
`timescale 1ns / 1ps

module leb_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  output logic             out_valid,
  input  logic             out_stall,
  input  leb_pkg::status_t status,
  output leb_pkg::cmd_t    cmd
);

  leb_pkg::state_t state;
  leb_pkg::state_t state_next;
  logic            out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= leb_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  assign out_valid_next = cmd.load_out | (out_valid & out_stall);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      leb_pkg::ST_IDLE: begin
        if (in_valid) state_next = leb_pkg::ST_DECODE;
      end
      leb_pkg::ST_DECODE: begin
        case (status.mode)
          leb_pkg::MODE_INSERT: begin
            if (status.char_zero || status.at_limit) state_next = leb_pkg::ST_DONE;
            else state_next = leb_pkg::ST_INS_CHK;
          end
          leb_pkg::MODE_BACKSPACE: begin
            if (status.cursor_zero) state_next = leb_pkg::ST_DONE;
            else state_next = leb_pkg::ST_BS_CHK;
          end
          leb_pkg::MODE_READ: begin
            if (status.idx_in_range) state_next = leb_pkg::ST_RD_WAIT;
            else state_next = leb_pkg::ST_DONE;
          end
          default: state_next = leb_pkg::ST_DONE;
        endcase
      end
      leb_pkg::ST_INS_CHK: begin
        if (status.ptr_gt_cursor) state_next = leb_pkg::ST_INS_WR;
        else state_next = leb_pkg::ST_DONE;
      end
      leb_pkg::ST_INS_WR: state_next = leb_pkg::ST_INS_CHK;
      leb_pkg::ST_BS_CHK: begin
        if (status.ptr_lt_length) state_next = leb_pkg::ST_BS_WR;
        else state_next = leb_pkg::ST_DONE;
      end
      leb_pkg::ST_BS_WR: state_next = leb_pkg::ST_BS_CHK;
      leb_pkg::ST_RD_WAIT: state_next = leb_pkg::ST_DONE;
      leb_pkg::ST_DONE: begin
        if (!out_valid || !out_stall) state_next = leb_pkg::ST_IDLE;
      end
      default: state_next = leb_pkg::ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd           = '0;
    cmd.raddr_sel = leb_pkg::RA_READ_IDX;
    in_stall      = 1'b1;
    cfg_ready     = 1'b0;
    case (state)
      leb_pkg::ST_IDLE: begin
        in_stall      = 1'b0;
        cfg_ready     = 1'b1;
        cmd.capture   = in_valid;
        cmd.cfg_write = cfg_valid;
      end
      leb_pkg::ST_DECODE: begin
        cmd.rd_clear = 1'b1;
        case (status.mode)
          leb_pkg::MODE_INSERT: begin
            cmd.mark_edit = !status.char_zero;
            cmd.ins_start = !status.char_zero && !status.at_limit;
          end
          leb_pkg::MODE_BACKSPACE: cmd.bs_start = !status.cursor_zero;
          leb_pkg::MODE_LEFT: begin
            cmd.mv_left   = 1'b1;
            cmd.mark_edit = 1'b1;
          end
          leb_pkg::MODE_RIGHT: begin
            cmd.mv_right  = 1'b1;
            cmd.mark_edit = 1'b1;
          end
          leb_pkg::MODE_CLEAR: begin
            cmd.clear     = 1'b1;
            cmd.mark_edit = 1'b1;
          end
          leb_pkg::MODE_ACK: cmd.ack = 1'b1;
          default: cmd.raddr_sel = leb_pkg::RA_READ_IDX;
        endcase
      end
      leb_pkg::ST_INS_CHK: begin
        cmd.raddr_sel  = leb_pkg::RA_INS_SRC;
        cmd.ins_finish = !status.ptr_gt_cursor;
      end
      leb_pkg::ST_INS_WR: cmd.ins_step = 1'b1;
      leb_pkg::ST_BS_CHK: begin
        cmd.raddr_sel = leb_pkg::RA_BS_SRC;
        cmd.bs_finish = !status.ptr_lt_length;
      end
      leb_pkg::ST_BS_WR: cmd.bs_step = 1'b1;
      leb_pkg::ST_RD_WAIT: cmd.rd_load = 1'b1;
      leb_pkg::ST_DONE: cmd.load_out = !out_valid || !out_stall;
      default: cmd = '0;
    endcase
  end

  // A result is never written over one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> !(out_valid && out_stall))
    else $error("result register overwritten while stalled");

  // Leaving the result state always leaves a result offered.
  a_done_offers: assert property (@(posedge clk) disable iff (rst)
    (state == leb_pkg::ST_DONE && state_next == leb_pkg::ST_IDLE) |=> out_valid)
    else $error("item finished without a result");

  // Store shift steps never run back to back without a read in between.
  a_step_after_chk: assert property (@(posedge clk) disable iff (rst)
    (state == leb_pkg::ST_INS_WR || state == leb_pkg::ST_BS_WR)
      |-> ($past(state) == leb_pkg::ST_INS_CHK || $past(state) == leb_pkg::ST_BS_CHK))
    else $error("shift write without preceding read");

endmodule

// ===== src/leb_datapath.sv =====
`timescale 1ns / 1ps

module leb_datapath #(
  parameter int DEPTH = 256
) (
  input  logic                       clk,
  input  logic                       rst,
  input  leb_pkg::cmd_t              cmd,
  output leb_pkg::status_t           status,
  input  logic [2:0]                 mode,
  input  logic [leb_pkg::CHAR_W-1:0] char_code,
  input  logic [leb_pkg::POS_W-1:0]  read_index,
  input  logic [leb_pkg::CAP_W-1:0]  capacity,
  output logic [leb_pkg::POS_W-1:0]  cursor_pos,
  output logic [leb_pkg::POS_W-1:0]  text_length,
  output logic                       changed,
  output logic [leb_pkg::CHAR_W-1:0] read_char
);

  localparam int LW = $clog2(DEPTH);
  localparam int XW = (LW > leb_pkg::POS_W) ? LW : leb_pkg::POS_W;
  localparam int CW = (LW + 1 > leb_pkg::CAP_W) ? LW + 1 : leb_pkg::CAP_W;
  localparam int RESET_LIMIT = ((DEPTH < 256) ? DEPTH : 256) - 1;

  logic [LW-1:0]              cursor;
  logic [LW-1:0]              length;
  logic [LW-1:0]              limit;
  logic [LW-1:0]              ptr;
  logic                       changed_flag;
  logic [2:0]                 mode_r;
  logic [leb_pkg::CHAR_W-1:0] char_r;
  logic [leb_pkg::POS_W-1:0]  idx_r;
  logic [leb_pkg::CHAR_W-1:0] rd_char;

  logic [LW-1:0]              newlen;
  logic [CW-1:0]              cap_x;
  logic [CW-1:0]              cap_eff;
  logic [XW-1:0]              idx_x;
  logic [XW-1:0]              len_x;
  logic [XW-1:0]              cur_x;

  logic                       we;
  logic [LW-1:0]              waddr;
  logic [leb_pkg::CHAR_W-1:0] wdata;
  logic [LW-1:0]              raddr;
  logic [leb_pkg::CHAR_W-1:0] rdata;

  // Capacity clamped into [2, DEPTH]; the text holds one less.
  assign cap_x   = CW'(capacity);
  assign cap_eff = (cap_x < CW'(2)) ? CW'(2) :
                   (cap_x > CW'(DEPTH)) ? CW'(DEPTH) : cap_x;

  assign newlen = (length < limit) ? length + LW'(1) : limit;
  assign idx_x  = XW'(idx_r);
  assign len_x  = XW'(length);
  assign cur_x  = XW'(cursor);

  assign status.mode          = mode_r;
  assign status.char_zero     = (char_r == '0);
  assign status.at_limit      = (cursor >= limit);
  assign status.cursor_zero   = (cursor == '0);
  assign status.ptr_gt_cursor = (ptr > cursor);
  assign status.ptr_lt_length = (ptr < length);
  assign status.idx_in_range  = (idx_x < len_x);

  always_comb begin
    case (cmd.raddr_sel)
      leb_pkg::RA_INS_SRC: raddr = ptr - LW'(1);
      leb_pkg::RA_BS_SRC:  raddr = ptr;
      default:             raddr = LW'(idx_x);
    endcase
  end

  assign we    = cmd.ins_step | cmd.ins_finish | cmd.bs_step;
  assign waddr = cmd.ins_step ? ptr : (cmd.ins_finish ? cursor : ptr - LW'(1));
  assign wdata = cmd.ins_finish ? char_r : rdata;

  leb_ram #(
    .WIDTH(leb_pkg::CHAR_W),
    .DEPTH(DEPTH),
    .AW   (LW)
  ) u_store (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor       <= '0;
      length       <= '0;
      changed_flag <= 1'b0;
      limit        <= LW'(RESET_LIMIT);
    end else begin
      if (cmd.cfg_write) begin
        limit  <= LW'(cap_eff - CW'(1));
        cursor <= '0;
        length <= '0;
      end else if (cmd.clear) begin
        cursor <= '0;
        length <= '0;
      end else if (cmd.mv_left) begin
        if (cursor != '0) cursor <= cursor - LW'(1);
      end else if (cmd.mv_right) begin
        if (cursor < length) cursor <= cursor + LW'(1);
      end else if (cmd.ins_finish) begin
        cursor <= cursor + LW'(1);
        length <= newlen;
      end else if (cmd.bs_finish) begin
        cursor <= cursor - LW'(1);
        length <= length - LW'(1);
      end
      if (cmd.mark_edit || cmd.bs_finish) begin
        changed_flag <= 1'b1;
      end else if (cmd.ack) begin
        changed_flag <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r <= mode;
      char_r <= char_code;
      idx_r  <= read_index;
    end
    if (cmd.ins_start) begin
      ptr <= newlen - LW'(1);
    end else if (cmd.ins_step) begin
      ptr <= ptr - LW'(1);
    end else if (cmd.bs_start) begin
      ptr <= cursor;
    end else if (cmd.bs_step) begin
      ptr <= ptr + LW'(1);
    end
    if (cmd.rd_clear) begin
      rd_char <= '0;
    end else if (cmd.rd_load) begin
      rd_char <= rdata;
    end
    if (cmd.load_out) begin
      cursor_pos  <= cur_x[leb_pkg::POS_W-1:0];
      text_length <= len_x[leb_pkg::POS_W-1:0];
      changed     <= changed_flag;
      read_char   <= rd_char;
    end
  end

  a_cursor_in_text: assert property (@(posedge clk) disable iff (rst)
    cursor <= length)
    else $error("cursor beyond end of text");

  a_length_in_limit: assert property (@(posedge clk) disable iff (rst)
    length <= limit)
    else $error("text longer than capacity allows");

  a_single_edit: assert property (@(posedge clk) disable iff (rst)
    $countones({cmd.cfg_write, cmd.clear, cmd.mv_left, cmd.mv_right,
                cmd.ins_finish, cmd.bs_finish}) <= 1)
    else $error("conflicting cursor updates");

endmodule
